@@ rtl/core/ble_advert_spam_detector_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the advert spam detector
// Immediate-implication and next-cycle-implication checks, compiled out when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BLE_ADVERT_SPAM_DETECTOR_MACROS_SVH
`define BLE_ADVERT_SPAM_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define BASD_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BASD_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define BASD_ASSERT_NOW(label, ck, rn, ante, cons)
`define BASD_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

@@ rtl/core/basd_pkg.sv @@
// ----------------------------------------------------------------------------
// Advert spam detector package
// Field widths, spam class constants, control structs and state types.
// ----------------------------------------------------------------------------
package basd_pkg;

    // Field widths.
    localparam int MAC_W      = 48;
    localparam int CID_W      = 16;
    localparam int SUB_W      = 8;
    localparam int UUID_W     = 16;
    localparam int HIST_IDX_W = 6;
    localparam int RATE_W     = 7;
    localparam int CLASS_W    = 16;
    localparam int TOTAL_W    = 32;
    localparam int THR_W      = 7;
    localparam int HOLD_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_HOLD      = 1'b1;
    localparam logic [THR_W-1:0]     THR_RESET           = 7'd20;
    localparam logic [HOLD_W-1:0]    HOLD_RESET          = 4'd4;

    // Spam class signatures.
    localparam logic [CID_W-1:0]  CID_CLASS_A = 16'h004C;
    localparam logic [CID_W-1:0]  CID_CLASS_B = 16'h0006;
    localparam logic [CID_W-1:0]  CID_CLASS_C = 16'h0075;
    localparam logic [SUB_W-1:0]  SUB_A_POPUP = 8'h0F;
    localparam logic [SUB_W-1:0]  SUB_A_ALT   = 8'h07;
    localparam logic [SUB_W-1:0]  SUB_B       = 8'h03;
    localparam logic [UUID_W-1:0] UUID_D      = 16'hFE2C;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ADVERT = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_READ   = 2'd2
    } req_t;

    // Class match flags for one advert.
    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } class_hits_t;

    // Sender table control and status.
    typedef struct packed {
        logic start;
        logic clear;
    } st_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } st_stat_t;

    // History ring control and status.
    typedef struct packed {
        logic push;
        logic read;
    } hist_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hist_stat_t;

    // State machine types.
    typedef enum logic [1:0] {
        TS_IDLE,
        TS_ADV_WAIT,
        TS_HIST_WAIT,
        TS_FINISH
    } top_state_t;

    typedef enum logic {
        SS_IDLE,
        SS_SCAN
    } st_state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MOD,
        HS_READ
    } hist_state_t;

    // Classify an advert from its pre-parsed fields.
    function automatic class_hits_t classify(
        input logic              has_maker,
        input logic [CID_W-1:0]  cid,
        input logic [SUB_W-1:0]  sub,
        input logic              has_svc,
        input logic [UUID_W-1:0] uuid
    );
        class_hits_t h;
        h = '0;
        if (has_maker) begin
            if (cid == CID_CLASS_A) begin
                h.a = (sub == SUB_A_POPUP) || (sub == SUB_A_ALT);
            end else if (cid == CID_CLASS_B) begin
                h.b = (sub == SUB_B);
            end else if (cid == CID_CLASS_C) begin
                h.c = 1'b1;
            end
        end
        h.d = has_svc && (uuid == UUID_D);
        return h;
    endfunction

endpackage

@@ rtl/core/basd_sender_table.sv @@
// ----------------------------------------------------------------------------
// Distinct sender table
// Walks the stored addresses one per cycle through a registered memory read
// and appends the address when it is new and room remains.
// ----------------------------------------------------------------------------
module basd_sender_table
    import basd_pkg::*;
#(
    parameter int SENDER_SLOTS = 96,
    localparam int CW = $clog2(SENDER_SLOTS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  st_ctrl_t         ctrl,
    input  logic [MAC_W-1:0] mac,
    output st_stat_t         stat,
    output logic [CW-1:0]    count
);

    localparam int IW = $clog2(SENDER_SLOTS);
    localparam logic [CW-1:0] SLOTS_C = CW'(SENDER_SLOTS);

    st_state_t        state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [MAC_W-1:0] mac_reg;
    logic [MAC_W-1:0] rd_data_reg;
    logic             rd_en;
    logic             wr_en;
    logic             done;

    logic [MAC_W-1:0] mem [SENDER_SLOTS];

    // Search sequencer: one read issued per cycle, compared in the cycle after.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            SS_IDLE:
            begin
                if (ctrl.clear) begin
                    count_next = '0;
                end
                if (ctrl.start) begin
                    idx_next   = '0;
                    state_next = SS_SCAN;
                end
            end
            SS_SCAN:
            begin
                if (pend_reg && (rd_data_reg == mac_reg)) begin
                    done       = 1'b1;
                    state_next = SS_IDLE;
                end else if (idx_reg < count_reg) begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    done       = 1'b1;
                    state_next = SS_IDLE;
                    if (count_reg < SLOTS_C) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = SS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= SS_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    // Address under search is held for the whole walk.
    always_ff @(posedge clk)
    begin
        if (ctrl.start && (state_reg == SS_IDLE)) begin
            mac_reg <= mac;
        end
    end

    // Address memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[count_reg[IW-1:0]] <= mac_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx_reg[IW-1:0]];
        end
    end

    assign stat.busy = (state_reg == SS_SCAN);
    assign stat.done = done;
    assign count     = count_reg;

endmodule

@@ rtl/core/basd_history.sv @@
// ----------------------------------------------------------------------------
// Distinct-count history ring
// Pushes one count per tick and reads an entry counted from the oldest, with
// unwritten entries reading as zero through a fill mark.
// ----------------------------------------------------------------------------
module basd_history
    import basd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int DATA_W = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hist_ctrl_t            ctrl,
    input  logic [DATA_W-1:0]     push_data,
    input  logic [HIST_IDX_W-1:0] read_index,
    output hist_stat_t            stat,
    output logic [DATA_W-1:0]     value
);

    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int SW = ((HW > HIST_IDX_W) ? HW : HIST_IDX_W) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);
    localparam logic [HW-1:0] LAST_C  = HW'(HISTORY_DEPTH - 1);

    hist_state_t           state_reg, state_next;
    logic [HW-1:0]         next_reg, next_next;
    logic                  wrapped_reg, wrapped_next;
    logic [HIST_IDX_W-1:0] rem_reg, rem_next;
    logic                  valid_reg, valid_next;
    logic [DATA_W-1:0]     rd_data_reg;
    logic [SW-1:0]         sum;
    logic [HW-1:0]         rd_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic                  done;

    logic [DATA_W-1:0] mem [HISTORY_DEPTH];

    // Physical address of the requested entry, oldest at the write pointer.
    assign sum     = SW'(next_reg) + SW'(rem_reg);
    assign rd_addr = (sum >= DEPTH_S) ? HW'(sum - DEPTH_S) : HW'(sum);

    // Push, index reduction and read sequencing.
    always_comb
    begin
        state_next   = state_reg;
        next_next    = next_reg;
        wrapped_next = wrapped_reg;
        rem_next     = rem_reg;
        valid_next   = valid_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        done         = 1'b0;
        unique case (state_reg)
            HS_IDLE:
            begin
                if (ctrl.push) begin
                    wr_en = 1'b1;
                    if (next_reg == LAST_C) begin
                        next_next    = '0;
                        wrapped_next = 1'b1;
                    end else begin
                        next_next = next_reg + 1'b1;
                    end
                end
                if (ctrl.read) begin
                    rem_next   = read_index;
                    state_next = HS_MOD;
                end
            end
            HS_MOD:
            begin
                if (SW'(rem_reg) >= DEPTH_S) begin
                    rem_next = HIST_IDX_W'(SW'(rem_reg) - DEPTH_S);
                end else begin
                    rd_en      = 1'b1;
                    valid_next = wrapped_reg || (rd_addr < next_reg);
                    state_next = HS_READ;
                end
            end
            HS_READ:
            begin
                done       = 1'b1;
                state_next = HS_IDLE;
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= HS_IDLE;
            next_reg    <= '0;
            wrapped_reg <= 1'b0;
            rem_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            next_reg    <= next_next;
            wrapped_reg <= wrapped_next;
            rem_reg     <= rem_next;
            valid_reg   <= valid_next;
        end
    end

    // Ring memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[next_reg] <= push_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign value     = valid_reg ? rd_data_reg : '0;
    assign stat.busy = (state_reg != HS_IDLE);
    assign stat.done = done;

endmodule

@@ rtl/core/ble_advert_spam_detector.sv @@
// ----------------------------------------------------------------------------
// Advert spam detector: one request at a time. A tick, an unused request or a
// non-spam advert goes straight to the finish state; a spam advert waits for
// the one-entry-per-cycle walk of the sender table, and a read for the index
// reduction and registered read of the history ring. The next request is
// taken once the result is loaded; a stalled result holds the next.
// Reset clears all counters and the ring fill mark; no clearing pass is run.
// ----------------------------------------------------------------------------
`include "ble_advert_spam_detector_macros.svh"

module ble_advert_spam_detector
    import basd_pkg::*;
#(
    parameter int SENDER_SLOTS = 96,
    parameter int HISTORY_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [MAC_W-1:0]      sender_mac,
    input  logic                  has_maker_data,
    input  logic [CID_W-1:0]      company_id,
    input  logic [SUB_W-1:0]      sub_type,
    input  logic                  has_service_data,
    input  logic [UUID_W-1:0]     service_uuid,
    input  logic [HIST_IDX_W-1:0] history_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_spam,
    output logic [CLASS_W-1:0]    class_a_hits,
    output logic [CLASS_W-1:0]    class_b_hits,
    output logic [CLASS_W-1:0]    class_c_hits,
    output logic [CLASS_W-1:0]    class_d_hits,
    output logic [TOTAL_W-1:0]    spam_total,
    output logic [RATE_W-1:0]     rate,
    output logic [RATE_W-1:0]     peak_rate,
    output logic                  alert,
    output logic [RATE_W-1:0]     history_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW   = $clog2(SENDER_SLOTS + 1);
    localparam int CMPW = (CW > THR_W) ? CW : THR_W;

    top_state_t         state_reg, state_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic [CLASS_W-1:0] live_a_reg, live_a_next;
    logic [CLASS_W-1:0] live_b_reg, live_b_next;
    logic [CLASS_W-1:0] live_c_reg, live_c_next;
    logic [CLASS_W-1:0] live_d_reg, live_d_next;
    logic [TOTAL_W-1:0] live_total_reg, live_total_next;
    logic [CLASS_W-1:0] snap_a_reg, snap_a_next;
    logic [CLASS_W-1:0] snap_b_reg, snap_b_next;
    logic [CLASS_W-1:0] snap_c_reg, snap_c_next;
    logic [CLASS_W-1:0] snap_d_reg, snap_d_next;
    logic [TOTAL_W-1:0] snap_total_reg, snap_total_next;
    logic [CW-1:0]      last_rate_reg, last_rate_next;
    logic [CW-1:0]      peak_reg, peak_next;
    logic [HOLD_W-1:0]  alert_left_reg, alert_left_next;
    logic               spam_reg, spam_next;
    logic [CW-1:0]      hval_reg, hval_next;
    logic               out_valid_reg, out_valid_next;
    logic               load_out;

    logic               out_spam_reg;
    logic [CLASS_W-1:0] out_a_reg;
    logic [CLASS_W-1:0] out_b_reg;
    logic [CLASS_W-1:0] out_c_reg;
    logic [CLASS_W-1:0] out_d_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [RATE_W-1:0]  out_rate_reg;
    logic [RATE_W-1:0]  out_peak_reg;
    logic               out_alert_reg;
    logic [RATE_W-1:0]  out_hval_reg;

    class_hits_t        hits;
    st_ctrl_t           st_ctrl;
    st_stat_t           st_stat;
    logic [CW-1:0]      sender_count;
    hist_ctrl_t         hist_ctrl;
    hist_stat_t         hist_stat;
    logic [CW-1:0]      hist_value;
    logic               over_thr;
    logic               units_busy;
    logic               units_waited;

    // Distinct sender table.
    basd_sender_table #(
        .SENDER_SLOTS(SENDER_SLOTS)
    ) u_sender_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (st_ctrl),
        .mac   (sender_mac),
        .stat  (st_stat),
        .count (sender_count)
    );

    // History ring of per-second distinct counts.
    basd_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .DATA_W       (CW)
    ) u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (hist_ctrl),
        .push_data  (sender_count),
        .read_index (history_index),
        .stat       (hist_stat),
        .value      (hist_value)
    );

    // Advert classification and alert trigger test.
    assign hits = classify(has_maker_data, company_id, sub_type,
                           has_service_data, service_uuid);
    assign over_thr = (CMPW'(sender_count) >= CMPW'(thr_reg));

    assign in_ready  = (state_reg == TS_IDLE);
    assign cfg_ready = 1'b1;

    // Request sequencing and counter updates.
    always_comb
    begin
        state_next      = state_reg;
        thr_next        = thr_reg;
        hold_next       = hold_reg;
        live_a_next     = live_a_reg;
        live_b_next     = live_b_reg;
        live_c_next     = live_c_reg;
        live_d_next     = live_d_reg;
        live_total_next = live_total_reg;
        snap_a_next     = snap_a_reg;
        snap_b_next     = snap_b_reg;
        snap_c_next     = snap_c_reg;
        snap_d_next     = snap_d_reg;
        snap_total_next = snap_total_reg;
        last_rate_next  = last_rate_reg;
        peak_next       = peak_reg;
        alert_left_next = alert_left_reg;
        spam_next       = spam_reg;
        hval_next       = hval_reg;
        load_out        = 1'b0;
        st_ctrl         = '0;
        hist_ctrl       = '0;

        // Configuration writes.
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_ALERT_THRESHOLD: thr_next  = cfg_data;
                REG_ALERT_HOLD:      hold_next = cfg_data[HOLD_W-1:0];
                default:             thr_next  = thr_reg;
            endcase
        end

        unique case (state_reg)
            TS_IDLE:
            begin
                if (in_valid) begin
                    spam_next  = 1'b0;
                    hval_next  = '0;
                    state_next = TS_FINISH;
                    unique case (req_type)
                        REQ_ADVERT:
                        begin
                            if (hits.a || hits.b || hits.c || hits.d) begin
                                spam_next = 1'b1;
                                if (hits.a) live_a_next = live_a_reg + 1'b1;
                                if (hits.b) live_b_next = live_b_reg + 1'b1;
                                if (hits.c) live_c_next = live_c_reg + 1'b1;
                                if (hits.d) live_d_next = live_d_reg + 1'b1;
                                live_total_next = live_total_reg + 1'b1;
                                st_ctrl.start   = 1'b1;
                                state_next      = TS_ADV_WAIT;
                            end
                        end
                        REQ_TICK:
                        begin
                            st_ctrl.clear   = 1'b1;
                            hist_ctrl.push  = 1'b1;
                            snap_a_next     = live_a_reg;
                            snap_b_next     = live_b_reg;
                            snap_c_next     = live_c_reg;
                            snap_d_next     = live_d_reg;
                            snap_total_next = live_total_reg;
                            last_rate_next  = sender_count;
                            if (sender_count > peak_reg) begin
                                peak_next = sender_count;
                            end
                            if (over_thr) begin
                                alert_left_next = hold_reg;
                            end else if (alert_left_reg != '0) begin
                                alert_left_next = alert_left_reg - 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            hist_ctrl.read = 1'b1;
                            state_next     = TS_HIST_WAIT;
                        end
                        default:
                        begin
                            state_next = TS_FINISH;
                        end
                    endcase
                end
            end
            TS_ADV_WAIT:
            begin
                if (st_stat.done) begin
                    state_next = TS_FINISH;
                end
            end
            TS_HIST_WAIT:
            begin
                if (hist_stat.done) begin
                    hval_next  = hist_value;
                    state_next = TS_FINISH;
                end
            end
            TS_FINISH:
            begin
                if (!out_valid_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = TS_IDLE;
                end
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase

        // Output register occupancy.
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control, configuration and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= TS_IDLE;
            thr_reg        <= THR_RESET;
            hold_reg       <= HOLD_RESET;
            live_a_reg     <= '0;
            live_b_reg     <= '0;
            live_c_reg     <= '0;
            live_d_reg     <= '0;
            live_total_reg <= '0;
            snap_a_reg     <= '0;
            snap_b_reg     <= '0;
            snap_c_reg     <= '0;
            snap_d_reg     <= '0;
            snap_total_reg <= '0;
            last_rate_reg  <= '0;
            peak_reg       <= '0;
            alert_left_reg <= '0;
            spam_reg       <= 1'b0;
            hval_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            hold_reg       <= hold_next;
            live_a_reg     <= live_a_next;
            live_b_reg     <= live_b_next;
            live_c_reg     <= live_c_next;
            live_d_reg     <= live_d_next;
            live_total_reg <= live_total_next;
            snap_a_reg     <= snap_a_next;
            snap_b_reg     <= snap_b_next;
            snap_c_reg     <= snap_c_next;
            snap_d_reg     <= snap_d_next;
            snap_total_reg <= snap_total_next;
            last_rate_reg  <= last_rate_next;
            peak_reg       <= peak_next;
            alert_left_reg <= alert_left_next;
            spam_reg       <= spam_next;
            hval_reg       <= hval_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result register, loaded once the request has finished.
    always_ff @(posedge clk)
    begin
        if (load_out) begin
            out_spam_reg  <= spam_reg;
            out_a_reg     <= snap_a_reg;
            out_b_reg     <= snap_b_reg;
            out_c_reg     <= snap_c_reg;
            out_d_reg     <= snap_d_reg;
            out_total_reg <= snap_total_reg;
            out_rate_reg  <= RATE_W'(last_rate_reg);
            out_peak_reg  <= RATE_W'(peak_reg);
            out_alert_reg <= (alert_left_reg != '0);
            out_hval_reg  <= RATE_W'(hval_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_spam       = out_spam_reg;
    assign class_a_hits  = out_a_reg;
    assign class_b_hits  = out_b_reg;
    assign class_c_hits  = out_c_reg;
    assign class_d_hits  = out_d_reg;
    assign spam_total    = out_total_reg;
    assign rate          = out_rate_reg;
    assign peak_rate     = out_peak_reg;
    assign alert         = out_alert_reg;
    assign history_value = out_hval_reg;

    // Sub-unit activity and the sequencer state that waits for it.
    assign units_busy   = st_stat.busy || hist_stat.busy;
    assign units_waited = (st_stat.busy && (state_reg == TS_ADV_WAIT))
                          || (hist_stat.busy && (state_reg == TS_HIST_WAIT));

    // The distinct count never passes the table capacity.
    `BASD_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, sender_count <= CW'(SENDER_SLOTS))

    // The last rate never exceeds the peak, and the peak never falls.
    `BASD_ASSERT_NOW(a_rate_below_peak, clk, rst_n, 1'b1, last_rate_reg <= peak_reg)
    `BASD_ASSERT_NEXT(a_peak_mono, clk, rst_n, 1'b1, peak_reg >= $past(peak_reg))

    // The sub-units work only while the sequencer waits for them.
    `BASD_ASSERT_NOW(a_unit_busy, clk, rst_n, units_busy, units_waited)

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Advert spam detector testbench
// Sends adverts, one-second ticks, history reads and unused requests through
// the request channel and checks every status transfer against a cycle-free
// model of the detector kept in this file. A directed burst comes first, then
// randomized seconds of adverts under several alert settings and idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import basd_pkg::*;

    localparam int SENDER_SLOTS  = 96;
    localparam int HISTORY_DEPTH = 64;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 165;
    localparam int STALL_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 120;

    // Request code that the block must ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // One request as it goes into the block.
    typedef struct packed {
        logic [1:0]            req;
        logic [MAC_W-1:0]      mac;
        logic                  maker;
        logic [CID_W-1:0]      cid;
        logic [SUB_W-1:0]      sub;
        logic                  svc;
        logic [UUID_W-1:0]     uuid;
        logic [HIST_IDX_W-1:0] hidx;
    } detector_req_t;

    // One status report as it comes out of the block.
    typedef struct packed {
        logic                  spam;
        logic [CLASS_W-1:0]    a_hits;
        logic [CLASS_W-1:0]    b_hits;
        logic [CLASS_W-1:0]    c_hits;
        logic [CLASS_W-1:0]    d_hits;
        logic [TOTAL_W-1:0]    total;
        logic [RATE_W-1:0]     rate;
        logic [RATE_W-1:0]     peak;
        logic                  alert;
        logic [RATE_W-1:0]     hval;
    } detector_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            req_type = '0;
    logic [MAC_W-1:0]      sender_mac = '0;
    logic                  has_maker_data = 1'b0;
    logic [CID_W-1:0]      company_id = '0;
    logic [SUB_W-1:0]      sub_type = '0;
    logic                  has_service_data = 1'b0;
    logic [UUID_W-1:0]     service_uuid = '0;
    logic [HIST_IDX_W-1:0] history_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  is_spam;
    logic [CLASS_W-1:0]    class_a_hits;
    logic [CLASS_W-1:0]    class_b_hits;
    logic [CLASS_W-1:0]    class_c_hits;
    logic [CLASS_W-1:0]    class_d_hits;
    logic [TOTAL_W-1:0]    spam_total;
    logic [RATE_W-1:0]     rate;
    logic [RATE_W-1:0]     peak_rate;
    logic                  alert;
    logic [RATE_W-1:0]     history_value;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ble_advert_spam_detector u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .sender_mac       (sender_mac),
        .has_maker_data   (has_maker_data),
        .company_id       (company_id),
        .sub_type         (sub_type),
        .has_service_data (has_service_data),
        .service_uuid     (service_uuid),
        .history_index    (history_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_spam          (is_spam),
        .class_a_hits     (class_a_hits),
        .class_b_hits     (class_b_hits),
        .class_c_hits     (class_c_hits),
        .class_d_hits     (class_d_hits),
        .spam_total       (spam_total),
        .rate             (rate),
        .peak_rate        (peak_rate),
        .alert            (alert),
        .history_value    (history_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // Requests waiting to be sent and status reports still owed by the block.
    detector_req_t    advert_req_q[$];
    detector_status_t expected_status_q[$];
    detector_req_t    drv_req = '0;

    int src_idle_pct = 15;
    int rcv_idle_pct = 61;
    int mismatch_cnt = 0;
    int stall_cycles = 0;

    // Shadow copy of the detector state and its alert settings.
    logic [CLASS_W-1:0]    live_a = '0, live_b = '0, live_c = '0, live_d = '0;
    logic [TOTAL_W-1:0]    live_sum = '0;
    logic [MAC_W-1:0]      mac_seen [SENDER_SLOTS];
    int                    mac_cnt = 0;
    logic [RATE_W-1:0]     hist_ring [HISTORY_DEPTH] = '{default: '0};
    logic [HIST_IDX_W-1:0] hist_next = '0;
    logic [CLASS_W-1:0]    snap_a = '0, snap_b = '0, snap_c = '0, snap_d = '0;
    logic [TOTAL_W-1:0]    snap_sum = '0;
    logic [RATE_W-1:0]     last_second = '0;
    logic [RATE_W-1:0]     peak_second = '0;
    logic [HOLD_W-1:0]     alert_ticks = '0;
    logic [THR_W-1:0]      cfg_threshold = THR_RESET;
    logic [HOLD_W-1:0]     cfg_hold = HOLD_RESET;

    // Advance the shadow detector by one request and return its status.
    function automatic detector_status_t predict_detector(input detector_req_t r);
        detector_status_t s;
        logic hit_a, hit_b, hit_c, hit_d, known;
        logic [RATE_W-1:0] distinct;
        logic [HIST_IDX_W-1:0] slot;
        s = '0;
        if (r.req == REQ_ADVERT) begin
            hit_a = r.maker && r.cid == CID_CLASS_A
                    && (r.sub == SUB_A_POPUP || r.sub == SUB_A_ALT);
            hit_b = r.maker && r.cid == CID_CLASS_B && r.sub == SUB_B;
            hit_c = r.maker && r.cid == CID_CLASS_C;
            hit_d = r.svc && r.uuid == UUID_D;
            if (hit_a || hit_b || hit_c || hit_d) begin
                s.spam = 1'b1;
                live_a = live_a + hit_a;
                live_b = live_b + hit_b;
                live_c = live_c + hit_c;
                live_d = live_d + hit_d;
                live_sum = live_sum + 1;
                // A new sender is kept only while the table has room.
                known = 1'b0;
                for (int i = 0; i < mac_cnt; i++) begin
                    if (mac_seen[i] == r.mac) known = 1'b1;
                end
                if (!known && mac_cnt < SENDER_SLOTS) begin
                    mac_seen[mac_cnt] = r.mac;
                    mac_cnt++;
                end
            end
        end else if (r.req == REQ_TICK) begin
            distinct = RATE_W'(mac_cnt);
            mac_cnt = 0;
            hist_ring[hist_next] = distinct;
            hist_next = hist_next + 1'b1;
            snap_a = live_a;
            snap_b = live_b;
            snap_c = live_c;
            snap_d = live_d;
            snap_sum = live_sum;
            last_second = distinct;
            if (distinct > peak_second) peak_second = distinct;
            if (distinct >= cfg_threshold) alert_ticks = cfg_hold;
            else if (alert_ticks != 0) alert_ticks = alert_ticks - 1'b1;
        end else if (r.req == REQ_READ) begin
            // Index 0 is the oldest entry, which is the next one to be written.
            slot = hist_next + r.hidx;
            s.hval = hist_ring[slot];
        end
        s.a_hits = snap_a;
        s.b_hits = snap_b;
        s.c_hits = snap_c;
        s.d_hits = snap_d;
        s.total  = snap_sum;
        s.rate   = last_second;
        s.peak   = peak_second;
        s.alert  = (alert_ticks != 0);
        return s;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    function automatic detector_req_t rand_request();
        detector_req_t r;
        r.req   = 2'($urandom_range(3));
        r.mac   = rand_mac();
        r.maker = 1'($urandom_range(1));
        r.cid   = CID_W'($urandom_range(16'hFFFF));
        r.sub   = SUB_W'($urandom_range(8'hFF));
        r.svc   = 1'($urandom_range(1));
        r.uuid  = UUID_W'($urandom_range(16'hFFFF));
        r.hidx  = HIST_IDX_W'($urandom_range(HISTORY_DEPTH - 1));
        return r;
    endfunction

    function automatic detector_req_t mk_req(
        input logic [1:0] req, input logic [MAC_W-1:0] mac, input logic maker,
        input logic [CID_W-1:0] cid, input logic [SUB_W-1:0] sub, input logic svc,
        input logic [UUID_W-1:0] uuid, input logic [HIST_IDX_W-1:0] hidx);
        detector_req_t r;
        r = '{req, mac, maker, cid, sub, svc, uuid, hidx};
        return r;
    endfunction

    // Build an advert that matches a class, or one that mostly misses narrowly.
    function automatic detector_req_t make_advert(input logic [MAC_W-1:0] mac,
                                                  input bit want_spam);
        detector_req_t r;
        r = rand_request();
        r.req = REQ_ADVERT;
        r.mac = mac;
        if (want_spam) begin
            case ($urandom_range(5))
                0: begin
                    r.maker = 1'b1;
                    r.cid = CID_CLASS_A;
                    r.sub = $urandom_range(1) ? SUB_A_POPUP : SUB_A_ALT;
                end
                1: begin
                    r.maker = 1'b1;
                    r.cid = CID_CLASS_B;
                    r.sub = SUB_B;
                end
                2: begin
                    r.maker = 1'b1;
                    r.cid = CID_CLASS_C;
                end
                3: begin
                    r.svc = 1'b1;
                    r.uuid = UUID_D;
                end
                4: begin
                    r.maker = 1'b1;
                    r.cid = CID_CLASS_A;
                    r.sub = SUB_A_ALT;
                    r.svc = 1'b1;
                    r.uuid = UUID_D;
                end
                default: begin
                    r.maker = 1'b1;
                    r.cid = CID_CLASS_C;
                    r.svc = 1'b1;
                    r.uuid = UUID_D;
                end
            endcase
        end else begin
            case ($urandom_range(4))
                0: ;
                1: begin
                    r.maker = 1'b1;
                    r.cid = CID_CLASS_A;
                end
                2: begin
                    r.maker = 1'b1;
                    r.cid = CID_CLASS_B;
                end
                3: begin
                    r.maker = 1'b0;
                    r.cid = $urandom_range(1) ? CID_CLASS_A : CID_CLASS_C;
                end
                default: begin
                    r.svc = 1'b0;
                    r.uuid = UUID_D;
                end
            endcase
        end
        return r;
    endfunction

    // Queue one second of traffic closed by a tick; sweep walks the sender
    // pool in order so that the distinct count can pass the table size.
    task automatic queue_second(input int n_adv, input int pool_sz, input int spam_pct,
                                input bit sweep, inout int queued);
        logic [MAC_W-1:0] pool [128];
        detector_req_t r;
        int roll;
        for (int i = 0; i < pool_sz; i++) pool[i] = rand_mac();
        for (int k = 0; k < n_adv; k++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                r = rand_request();
                r.req = REQ_READ;
            end else if (roll < 6) begin
                r = rand_request();
                r.req = REQ_UNUSED;
            end else begin
                r = make_advert(sweep ? pool[k % pool_sz] : pool[$urandom_range(pool_sz - 1)],
                                $urandom_range(99) < spam_pct);
            end
            advert_req_q.push_back(r);
        end
        r = rand_request();
        r.req = REQ_TICK;
        advert_req_q.push_back(r);
        queued += n_adv + 1;
    endtask

    // Write one alert register and mirror it in the shadow settings.
    task automatic write_detector_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ALERT_THRESHOLD) cfg_threshold = data[THR_W-1:0];
        else cfg_hold = data[HOLD_W-1:0];
    endtask

    // Wait until everything sent has been answered.
    task automatic wait_drained();
        while (advert_req_q.size() != 0 || in_valid || expected_status_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Request driver: a transfer at this edge is predicted, then the next
    // request is offered unless the sender idles.
    always @(posedge clk) begin : request_driver
        logic launch;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_status_q.push_back(predict_detector(drv_req));
            end
            if (!in_valid || in_ready) begin
                launch = (advert_req_q.size() != 0) && ($urandom_range(99) >= src_idle_pct);
                if (launch) begin
                    drv_req = advert_req_q.pop_front();
                    req_type         <= drv_req.req;
                    sender_mac       <= drv_req.mac;
                    has_maker_data   <= drv_req.maker;
                    company_id       <= drv_req.cid;
                    sub_type         <= drv_req.sub;
                    has_service_data <= drv_req.svc;
                    service_uuid     <= drv_req.uuid;
                    history_index    <= drv_req.hidx;
                end
                in_valid <= launch;
            end
        end
    end

    // Status monitor: compare each transfer with the oldest expected status.
    always @(posedge clk) begin : status_monitor
        detector_status_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t: status transfer with none expected, expected none, actual %0h",
                         $time, {is_spam, spam_total, rate, history_value});
                mismatch_cnt++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("is_spam",       32'(want.spam),   32'(is_spam));
                check_field("class_a_hits",  32'(want.a_hits), 32'(class_a_hits));
                check_field("class_b_hits",  32'(want.b_hits), 32'(class_b_hits));
                check_field("class_c_hits",  32'(want.c_hits), 32'(class_c_hits));
                check_field("class_d_hits",  32'(want.d_hits), 32'(class_d_hits));
                check_field("spam_total",    want.total,       spam_total);
                check_field("rate",          32'(want.rate),   32'(rate));
                check_field("peak_rate",     32'(want.peak),   32'(peak_rate));
                check_field("alert",         32'(want.alert),  32'(alert));
                check_field("history_value", 32'(want.hval),   32'(history_value));
            end
        end
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin : stall_watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        int thr_set  [PHASE_COUNT];
        int hold_set [PHASE_COUNT];
        int queued;
        logic [MAC_W-1:0] mac_one;

        thr_set  = '{0, 96, 5, 12, 95, 30, 1, 64, 8};
        hold_set = '{15, 1, 0, 7, 10, 3, 15, 8, 2};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: each class, near misses,
        // double-class adverts, field extremes, reads and the unused code.
        mac_one = rand_mac();
        advert_req_q.push_back(mk_req(REQ_ADVERT, mac_one, 1'b1, CID_CLASS_A, SUB_A_POPUP,
                                      1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, mac_one, 1'b1, CID_CLASS_A, SUB_A_ALT,
                                      1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, mac_one, 1'b1, CID_CLASS_A, 8'h10,
                                      1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, 48'h1, 1'b1, CID_CLASS_B, SUB_B,
                                      1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, 48'h2, 1'b1, CID_CLASS_B, 8'h04,
                                      1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, '1, 1'b1, CID_CLASS_C, 8'hFF,
                                      1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, '0, 1'b0, '0, '0, 1'b1, UUID_D, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, 48'h3, 1'b0, '0, '0, 1'b0, UUID_D, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, 48'h4, 1'b0, CID_CLASS_A, SUB_A_POPUP,
                                      1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, 48'h5, 1'b1, CID_CLASS_A, SUB_A_POPUP,
                                      1'b1, UUID_D, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, 48'h6, 1'b1, CID_CLASS_C, '0,
                                      1'b1, UUID_D, '0));
        advert_req_q.push_back(mk_req(REQ_UNUSED, '1, 1'b1, '1, '1, 1'b1, '1, '1));
        advert_req_q.push_back(mk_req(REQ_READ, '0, 1'b0, '0, '0, 1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_TICK, '0, 1'b0, '0, '0, 1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_READ, '0, 1'b0, '0, '0, 1'b0, '0, '1));
        advert_req_q.push_back(mk_req(REQ_READ, '1, 1'b1, '1, '1, 1'b1, '1, '0));
        advert_req_q.push_back(mk_req(REQ_ADVERT, '1, 1'b1, '1, '1, 1'b1, '1, '1));
        advert_req_q.push_back(mk_req(REQ_ADVERT, '0, 1'b0, '0, '0, 1'b0, '0, '0));
        advert_req_q.push_back(mk_req(REQ_TICK, '1, 1'b1, '1, '1, 1'b1, '1, '1));
        advert_req_q.push_back(mk_req(REQ_READ, '0, 1'b0, '0, '0, 1'b0, '0, 6'd1));
        advert_req_q.push_back(mk_req(REQ_UNUSED, '0, 1'b0, '0, '0, 1'b0, '0, '0));
        wait_drained();

        // Random seconds under each alert setting; each phase drains fully
        // before the registers change.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_detector_reg(REG_ALERT_THRESHOLD, CFG_DATA_W'(thr_set[p]));
            write_detector_reg(REG_ALERT_HOLD, CFG_DATA_W'(hold_set[p]));
            if (p < 3) begin
                src_idle_pct = 15;
                rcv_idle_pct = 61;
            end else if (p < 6) begin
                src_idle_pct = 61;
                rcv_idle_pct = 15;
            end else begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            queued = 0;
            // High thresholds get one second that overfills the sender table.
            if (thr_set[p] >= 64) queue_second(140, 110, 100, 1, queued);
            while (queued < PHASE_ITEMS) begin
                if ($urandom_range(19) == 0)
                    queue_second(130, 105, 100, 1, queued);
                else
                    queue_second($urandom_range(45), $urandom_range(1, 40),
                                 $urandom_range(30, 95), 0, queued);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && expected_status_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
